// File: rtl/bss_pkg.sv
// shared types and constants of the bounded stack with search
package bss_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 9;
  localparam int unsigned PosW  = 9;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned AddrW = 3;

  localparam logic [CapW-1:0]  CapReset = 9'd256;
  localparam logic [AddrW-1:0] CapAddr  = 3'd0;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_TOP    = 3'd2,
    CMD_EMPTY  = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_CAP,
    ST_SRCH,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pop_cap;
    logic srch;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_zero;
    logic fill_one;
    logic hit;
    logic ptr_zero;
  } dp_stat_t;

endpackage

// File: rtl/bss_ctrl.sv
// controller state machine of the bounded stack with search
module bss_ctrl
  import bss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [CmdW-1:0]   command_i,
  input  logic              out_stall_i,
  input  dp_stat_t          stat_i,
  output dp_cmd_t           cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if ((command_i == CMD_POP) && !stat_i.fill_zero && !stat_i.fill_one) begin
            state_d = ST_POP_CAP;
          end else if ((command_i == CMD_SEARCH) && !stat_i.fill_zero) begin
            state_d = ST_SRCH;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_POP_CAP: begin
        cmd_o.pop_cap = 1'b1;
        state_d       = ST_DONE;
      end
      ST_SRCH: begin
        cmd_o.srch = 1'b1;
        if (stat_i.hit || stat_i.ptr_zero) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/bss_dp.sv
// datapath of the bounded stack with search: store, fill count, search walk
module bss_dp
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  logic [CmdW-1:0]         command_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic [CapW-1:0]         cap_i,
  output dp_stat_t                stat_o,
  output logic signed [DataW-1:0] top_value_o,
  output logic                    top_valid_o,
  output logic                    is_empty_o,
  output logic [PosW-1:0]         position_o,
  output logic                    status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > CapW) ? CW : CapW;

  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rd_data_q;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;

  logic [CW-1:0]    fill_q;
  logic [AW-1:0]    ptr_q;
  logic [DataW-1:0] key_q;
  logic [DataW-1:0] top_q;
  logic             status_q;
  logic [PosW-1:0]  pos_q;
  logic             can_push;
  logic [CW-1:0]    depth_found;

  // room left under both the capacity register and the store depth
  assign can_push = (MW'(fill_q) < MW'(cap_i)) && (MW'(fill_q) < MW'(DEPTH));
  assign mem_we   = cmd_i.accept && (command_i == CMD_PUSH) && can_push;

  // read address: below top on pop, top on search start, walk down otherwise
  always_comb begin
    rd_addr = ptr_q - AW'(1);
    if (cmd_i.accept) begin
      if (command_i == CMD_POP) begin
        rd_addr = AW'(fill_q - CW'(2));
      end else begin
        rd_addr = AW'(fill_q - CW'(1));
      end
    end
  end

  // stack store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(fill_q)] <= value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.accept) begin
      if (mem_we) begin
        fill_q <= fill_q + CW'(1);
      end else if ((command_i == CMD_POP) && (fill_q != '0)) begin
        fill_q <= fill_q - CW'(1);
      end
    end
  end

  assign depth_found = fill_q - CW'(ptr_q);

  // top word, search walk and per-word result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      status_q <= 1'b0;
      pos_q    <= '0;
      key_q    <= value_i;
      ptr_q    <= AW'(fill_q - CW'(1));
      unique case (cmd_e'(command_i))
        CMD_PUSH: begin
          if (can_push) begin
            top_q <= value_i;
          end else begin
            status_q <= 1'b1;
          end
        end
        CMD_POP: begin
          if (fill_q == '0) begin
            status_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.pop_cap) begin
      top_q <= rd_data_q;
    end
    if (cmd_i.srch) begin
      if (rd_data_q == key_q) begin
        pos_q <= PosW'(depth_found);
      end else begin
        ptr_q <= ptr_q - AW'(1);
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      top_value_o <= (fill_q != '0) ? top_q : '1;
      top_valid_o <= (fill_q != '0);
      is_empty_o  <= (fill_q == '0);
      position_o  <= pos_q;
      status_o    <= status_q;
    end
  end

  assign stat_o.fill_zero = (fill_q == '0);
  assign stat_o.fill_one  = (fill_q == CW'(1));
  assign stat_o.hit       = (rd_data_q == key_q);
  assign stat_o.ptr_zero  = (ptr_q == '0);

endmodule

// File: rtl/bounded_stack_with_search.sv
// bounded lifo stack with search, one word in flight at a time
// result loaded from the done state after accept; a pop from two or more entries
// passes the pop state first, and a search reads entries in the search state
// (one per cycle, none on an empty stack); the next word is taken back in idle
// a result stalled at the output holds back the next load
// reset clears fill count and output valid, capacity returns to 256
module bounded_stack_with_search
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CmdW-1:0]         command_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] top_value_o,
  output logic                    top_valid_o,
  output logic                    is_empty_o,
  output logic [PosW-1:0]         position_o,
  output logic                    status_o
);

  logic [CapW-1:0] cap_q;
  dp_cmd_t         dp_cmd;
  dp_stat_t        dp_stat;

  // capacity register on the apb port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (psel && penable && pwrite && (paddr == CapAddr)) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == CapAddr) ? {{(32 - CapW){1'b0}}, cap_q} : '0;

  bss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  bss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .command_i   (command_i),
    .value_i     (value_i),
    .cap_i       (cap_q),
    .stat_o      (dp_stat),
    .top_value_o (top_value_o),
    .top_valid_o (top_valid_o),
    .is_empty_o  (is_empty_o),
    .position_o  (position_o),
    .status_o    (status_o)
  );

endmodule

// File: rtl/bss_chk.sv
// port-level checks of the bounded stack with search, bound to the top level
module bss_chk
  import bss_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [DataW-1:0] top_value_o,
  input logic                    top_valid_o,
  input logic                    is_empty_o,
  input logic [PosW-1:0]         position_o,
  input logic                    status_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(top_value_o)
      && $stable(position_o) && $stable(status_o))
    else $error("stalled result word changed");

  // valid and empty flags are complements
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_valid_o != is_empty_o))
    else $error("top_valid and is_empty disagree");

  // empty stack shows all ones on top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (top_value_o == -1))
    else $error("empty stack top is not all ones");

  // a flagged push or pop never reports a search position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> (position_o == '0))
    else $error("flagged word carries a position");

  // a found key implies a non-empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (position_o != '0) |-> top_valid_o)
    else $error("position reported on empty stack");

endmodule

bind bounded_stack_with_search bss_chk u_bss_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .top_value_o (top_value_o),
  .top_valid_o (top_valid_o),
  .is_empty_o  (is_empty_o),
  .position_o  (position_o),
  .status_o    (status_o)
);

// File: tb/bounded_stack_with_search_tb.sv
// testbench for the bounded stack with search: directed cases, random mixes, full-depth fill
`timescale 1ns / 100ps

module bounded_stack_with_search_tb
  import bss_pkg::*;
();

  localparam int unsigned StackDepth  = 256;
  localparam int          DrainCycles = 8;
  localparam int          ReportLimit = 10;

  localparam logic [CmdW-1:0]  CmdBadFirst = 3'd5;
  localparam logic [CmdW-1:0]  CmdBadLast  = 3'd7;
  localparam logic [DataW-1:0] EmptyTop    = '1;
  localparam logic [DataW-1:0] WordMin     = 32'h8000_0000;
  localparam logic [DataW-1:0] WordMax     = 32'h7fff_ffff;
  localparam logic [DataW-1:0] BottomMark  = 32'h5a5a_c3c3;
  localparam logic [CapW-1:0]  CapOver     = 9'd511;

  // one result word as the block reports it
  typedef struct packed {
    logic signed [DataW-1:0] top_value;
    logic                    top_valid;
    logic                    is_empty;
    logic [PosW-1:0]         position;
    logic                    status;
  } stack_view_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [AddrW-1:0]        paddr       = '0;
  logic [31:0]             pwdata      = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [CmdW-1:0]         command_i   = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [DataW-1:0] top_value_o;
  logic                    top_valid_o;
  logic                    is_empty_o;
  logic [PosW-1:0]         position_o;
  logic                    status_o;

  // predictor state
  logic [DataW-1:0] stack_mem [StackDepth];
  int               fill_level = 0;
  logic [CapW-1:0]  cap_reg    = CapReset;

  stack_view_t awaited_views[$];
  int          mismatch_count = 0;
  int          idle_pct       = 0;
  int          stall_pct      = 0;

  bounded_stack_with_search #(
    .DEPTH(StackDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .top_value_o(top_value_o),
    .top_valid_o(top_valid_o),
    .is_empty_o (is_empty_o),
    .position_o (position_o),
    .status_o   (status_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // applies one command to the predicted stack and returns the word it should report
  function automatic stack_view_t stack_apply(input logic [CmdW-1:0] cmd,
                                              input logic [DataW-1:0] word);
    stack_view_t v;
    int          limit;
    int          d;
    v = '0;
    limit = (cap_reg > StackDepth) ? StackDepth : int'(cap_reg);
    case (cmd)
      CMD_PUSH: begin
        if (fill_level < limit) begin
          stack_mem[fill_level] = word;
          fill_level++;
        end else begin
          v.status = 1'b1;
        end
      end
      CMD_POP: begin
        if (fill_level != 0) fill_level--;
        else v.status = 1'b1;
      end
      CMD_SEARCH: begin
        // walk up from the bottom so the shallowest match is kept
        for (d = fill_level; d >= 1; d--) begin
          if (stack_mem[fill_level - d] == word) v.position = PosW'(d);
        end
      end
      default: ;
    endcase
    v.top_valid = (fill_level != 0);
    v.is_empty  = (fill_level == 0);
    v.top_value = (fill_level != 0) ? stack_mem[fill_level - 1] : EmptyTop;
    return v;
  endfunction

  // operand mix: extremes, small values that repeat, and full random
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(9))
      0: return WordMin;
      1: return WordMax;
      2: return EmptyTop;
      3: return '0;
      4, 5: return DataW'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  // search key: mostly one that sits in the stack
  function automatic logic [DataW-1:0] stored_key();
    if (fill_level == 0 || $urandom_range(3) == 0) return pick_word();
    return stack_mem[$urandom_range(fill_level - 1)];
  endfunction

  function automatic logic [CmdW-1:0] pick_command(input int push_pct);
    int r;
    if ($urandom_range(99) < push_pct) return CMD_PUSH;
    r = $urandom_range(99);
    if (r < 45) return CMD_POP;
    if (r < 75) return CMD_SEARCH;
    if (r < 85) return CMD_TOP;
    if (r < 95) return CMD_EMPTY;
    return CmdBadFirst + CmdW'($urandom_range(CmdBadLast - CmdBadFirst));
  endfunction

  // sends one word; valid stays high after acceptance unless a gap follows
  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_views.push_back(stack_apply(cmd, word));
  endtask

  // lowers valid and waits until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_views.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // capacity write over the register port, only with the block idle
  task automatic set_capacity(input logic [CapW-1:0] cap);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CapAddr;
    pwdata  <= 32'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg = cap;
  endtask

  // reads and flags on an empty stack, unknown commands
  task automatic test_empty_stack();
    logic [CmdW-1:0] c;
    send_word(CMD_TOP, pick_word());
    send_word(CMD_EMPTY, pick_word());
    send_word(CMD_POP, pick_word());
    send_word(CMD_SEARCH, '0);
    for (c = CmdBadFirst; c != CmdBadFirst - 1'b1; c++) begin
      send_word(c, $urandom);
      if (c == CmdBadLast) break;
    end
  endtask

  // pushes of extreme words, searches at several depths and a miss
  task automatic test_push_search();
    send_word(CMD_PUSH, WordMin);
    send_word(CMD_PUSH, WordMax);
    send_word(CMD_PUSH, EmptyTop);
    send_word(CMD_PUSH, WordMax);
    send_word(CMD_SEARCH, WordMax);
    send_word(CMD_SEARCH, WordMin);
    send_word(CMD_SEARCH, 32'h0001_2345);
    send_word(CMD_TOP, '0);
    send_word(CMD_EMPTY, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_SEARCH, WordMax);
  endtask

  // capacity below the fill level, zero and one
  task automatic test_capacity_limits();
    set_capacity(9'd2);
    send_word(CMD_PUSH, 32'h0000_0011);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_PUSH, 32'h0000_0022);
    set_capacity('0);
    send_word(CMD_PUSH, 32'h0000_0033);
    send_word(CMD_POP, '0);
    send_word(CMD_POP, '0);
    set_capacity(9'd1);
    send_word(CMD_PUSH, 32'hdead_beef);
    send_word(CMD_PUSH, 32'h0000_0044);
    send_word(CMD_POP, '0);
  endtask

  // random commands with bursts of push, search and pop
  task automatic test_random_mix(input int count, input logic [CapW-1:0] cap,
                                 input int idle, input int stall, input int push_pct);
    int              sent;
    int              k;
    int              i;
    logic [CmdW-1:0] cmd;
    set_capacity(cap);
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        k = $urandom_range(6, 1);
        for (i = 0; i < k; i++) send_word(CMD_PUSH, pick_word());
        for (i = 0; i < k; i++) send_word(CMD_SEARCH, stored_key());
        for (i = 0; i < k; i++) send_word(CMD_POP, $urandom);
        sent += 3 * k;
      end else begin
        cmd = pick_command(push_pct);
        send_word(cmd, (cmd == CMD_SEARCH) ? stored_key() : pick_word());
        sent++;
      end
    end
  endtask

  // fill to full depth with an oversized capacity, search deep, empty again
  task automatic test_fill_to_depth();
    int i;
    set_capacity(CapOver);
    idle_pct  = 21;
    stall_pct = 21;
    while (fill_level > 0) send_word(CMD_POP, $urandom);
    send_word(CMD_PUSH, BottomMark);
    while (fill_level < StackDepth) send_word(CMD_PUSH, pick_word());
    send_word(CMD_PUSH, $urandom);
    send_word(CMD_PUSH, $urandom);
    send_word(CMD_SEARCH, BottomMark);
    send_word(CMD_SEARCH, $urandom);
    for (i = 0; i < 8; i++) send_word(CMD_SEARCH, stored_key());
    while (fill_level > 0) send_word(CMD_POP, $urandom);
    send_word(CMD_POP, $urandom);
  endtask

  // result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    stack_view_t seen;
    stack_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{top_value_o, top_valid_o, is_empty_o, position_o, status_o};
      if (awaited_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected word: top %h valid %0b empty %0b pos %0d status %0b",
                   seen.top_value, seen.top_valid, seen.is_empty, seen.position,
                   seen.status);
      end else begin
        want = awaited_views.pop_front();
        if (seen.top_value !== want.top_value || seen.top_valid !== want.top_valid ||
            seen.is_empty !== want.is_empty || seen.position !== want.position ||
            seen.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("mismatch: expected top %h valid %0b empty %0b pos %0d status %0b",
                     want.top_value, want.top_valid, want.is_empty, want.position,
                     want.status);
            $display("          actual   top %h valid %0b empty %0b pos %0d status %0b",
                     seen.top_value, seen.top_valid, seen.is_empty, seen.position,
                     seen.status);
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stack();
    test_push_search();
    test_capacity_limits();
    test_random_mix(220, 9'd8, 0, 0, 45);
    test_random_mix(180, 9'd3, 62, 0, 50);
    test_random_mix(220, 9'd37, 0, 62, 60);
    test_random_mix(40, '0, 21, 21, 40);
    test_random_mix(250, CapReset, 0, 0, 50);
    test_fill_to_depth();
    drain();
    if (mismatch_count == 0) begin
      $display("bounded_stack_with_search_tb: done, clean");
    end else begin
      $display("bounded_stack_with_search_tb: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("bounded_stack_with_search_tb: done, errors");
    $finish;
  end

endmodule
